### hw/rtl/pld_pkg.sv
// Shared constants, codes and types for the positional list block.
`timescale 1ns / 1ps
package pld_pkg;

    localparam int LIST_CAPACITY = 32;
    localparam int CNT_W = $clog2(LIST_CAPACITY + 1);
    localparam int POS_W = 6;
    localparam int LEN_W = 6;
    localparam int VAL_W = 32;
    localparam int CMP_W = POS_W + CNT_W;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_PRINT  = 2'd2;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_ELEMENT = 2'd1;
    localparam logic [1:0] KIND_EMPTY   = 2'd2;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;
    localparam logic [1:0] OP_ROT  = 2'd3;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_PRINT = 1'b1;

    typedef struct packed {
        logic [1:0]       op;
        logic [CMP_W-1:0] pos_idx;
        logic [CMP_W-1:0] last_idx;
        logic [VAL_W-1:0] new_value;
    } t_cell_ctrl;

endpackage

### hw/rtl/pld_if.sv
// Command and result channel interfaces of the positional list block.
`timescale 1ns / 1ps
interface pld_cmd_if
    import pld_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [1:0]              command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] new_value;

    modport source (output valid, output command, output position, output new_value,
                    input ready);
    modport sink   (input valid, input command, input position, input new_value,
                    output ready);
endinterface

interface pld_res_if
    import pld_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [1:0]              result_kind;
    logic [1:0]              op_status;
    logic signed [VAL_W-1:0] element_value;
    logic [LEN_W-1:0]        list_length;
    logic                    last_result;

    modport source (output valid, output result_kind, output op_status,
                    output element_value, output list_length, output last_result,
                    input ready);
    modport sink   (input valid, input result_kind, input op_status,
                    input element_value, input list_length, input last_result,
                    output ready);
endinterface

### hw/rtl/positional_list_insert_delete.sv
// Top level of the positional list: command decode, cell chain and result register.
`timescale 1ns / 1ps
// Bounded ordered list of up to LIST_CAPACITY signed 32-bit entries, one entry per
// cell in a chain. Insert and delete shift every affected cell at once, giving a
// single acknowledgement in the result register on the next cycle. Print accepts
// the command, then rotates the occupied cells one place per cycle while the result
// channel is not stalled and emits the head cell at each step, so a print of a
// non-empty list gives one element per stored entry. A print of an empty list gives
// a single empty result. The rotation leaves the order as it was. A command is taken
// only when no print is in progress and the result register is empty or drained in
// the same cycle. Stalls on the result channel hold the block for as long as they last.
module positional_list_insert_delete
    import pld_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    pld_cmd_if.sink    i_cmd,
    pld_res_if.source  o_res
);

    logic             r_state;
    logic             n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_left;
    logic [CNT_W-1:0] n_left;

    logic             r_out_valid;
    logic             n_out_valid;
    logic [1:0]       r_kind;
    logic [1:0]       n_kind;
    logic [1:0]       r_status;
    logic [1:0]       n_status;
    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;
    logic [LEN_W-1:0] r_length;
    logic [LEN_W-1:0] n_length;
    logic             r_last;
    logic             n_last;

    logic             out_free;
    logic             accept;
    logic             print_step;
    logic             ins_range_ok;
    logic             del_range_ok;
    logic             list_full;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] pos_ext;
    t_cell_ctrl       cell_ctrl;
    logic [VAL_W-1:0] cell_val [LIST_CAPACITY];

    assign out_free     = !r_out_valid || o_res.ready;
    assign i_cmd.ready  = (r_state == ST_IDLE) && out_free;
    assign accept       = i_cmd.valid && i_cmd.ready;
    assign print_step   = (r_state == ST_PRINT) && out_free;
    assign cnt_ext      = CMP_W'(r_count);
    assign pos_ext      = CMP_W'(i_cmd.position);
    assign ins_range_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
    assign del_range_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign list_full    = (r_count == CNT_W'(LIST_CAPACITY));

    always_comb begin
        cell_ctrl.op        = OP_HOLD;
        cell_ctrl.pos_idx   = pos_ext - CMP_W'(1);
        cell_ctrl.last_idx  = cnt_ext - CMP_W'(1);
        cell_ctrl.new_value = i_cmd.new_value;

        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_out_valid = r_out_valid && !o_res.ready;
        n_kind      = r_kind;
        n_status    = r_status;
        n_value     = r_value;
        n_length    = r_length;
        n_last      = r_last;

        if (accept) begin
            n_out_valid = 1'b1;
            n_kind      = KIND_ACK;
            n_status    = STATUS_RANGE;
            n_value     = '0;
            n_last      = 1'b1;
            case (i_cmd.command)
                CMD_INSERT: begin
                    if (ins_range_ok && !list_full) begin
                        cell_ctrl.op = OP_INS;
                        n_count      = r_count + CNT_W'(1);
                        n_status     = STATUS_DONE;
                    end else if (ins_range_ok) begin
                        n_status = STATUS_FULL;
                    end
                end
                CMD_DELETE: begin
                    if (del_range_ok) begin
                        cell_ctrl.op = OP_DEL;
                        n_count      = r_count - CNT_W'(1);
                        n_status     = STATUS_DONE;
                    end
                end
                CMD_PRINT: begin
                    n_status = STATUS_DONE;
                    if (r_count == '0) begin
                        n_kind = KIND_EMPTY;
                    end else begin
                        n_out_valid = r_out_valid && !o_res.ready;
                        n_state     = ST_PRINT;
                        n_left      = r_count;
                    end
                end
                default: begin
                    n_status = STATUS_RANGE;
                end
            endcase
            n_length = LEN_W'(n_count);
        end else if (print_step) begin
            cell_ctrl.op = OP_ROT;
            n_out_valid  = 1'b1;
            n_kind       = KIND_ELEMENT;
            n_status     = STATUS_DONE;
            n_value      = cell_val[0];
            n_length     = LEN_W'(r_count);
            n_last       = (r_left == CNT_W'(1));
            n_left       = r_left - CNT_W'(1);
            if (r_left == CNT_W'(1)) begin
                n_state = ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_status <= n_status;
        r_value  <= n_value;
        r_length <= n_length;
        r_last   <= n_last;
    end

    for (genvar g = 0; g < LIST_CAPACITY; g++) begin : g_cell
        logic [VAL_W-1:0] left_val;
        logic [VAL_W-1:0] right_val;
        if (g == 0) begin : g_head
            assign left_val = cell_ctrl.new_value;
        end else begin : g_body
            assign left_val = cell_val[g-1];
        end
        if (g == LIST_CAPACITY - 1) begin : g_tail
            assign right_val = cell_val[g];
        end else begin : g_inner
            assign right_val = cell_val[g+1];
        end
        pld_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (cell_ctrl),
            .i_index (CMP_W'(g)),
            .i_left  (left_val),
            .i_right (right_val),
            .i_first (cell_val[0]),
            .o_value (cell_val[g])
        );
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.result_kind   = r_kind;
    assign o_res.op_status     = r_status;
    assign o_res.element_value = r_value;
    assign o_res.list_length   = r_length;
    assign o_res.last_result   = r_last;

endmodule

### hw/rtl/pld_cell.sv
// One list cell: holds one entry and takes a neighbor's value on shift or rotate.
`timescale 1ns / 1ps
module pld_cell
    import pld_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctrl       i_ctrl,
    input  logic [CMP_W-1:0] i_index,
    input  logic [VAL_W-1:0] i_left,
    input  logic [VAL_W-1:0] i_right,
    input  logic [VAL_W-1:0] i_first,
    output logic [VAL_W-1:0] o_value
);

    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            OP_INS: begin
                if (i_index == i_ctrl.pos_idx) begin
                    n_value = i_ctrl.new_value;
                end else if (i_index > i_ctrl.pos_idx) begin
                    n_value = i_left;
                end
            end
            OP_DEL: begin
                if (i_index >= i_ctrl.pos_idx) begin
                    n_value = i_right;
                end
            end
            OP_ROT: begin
                if (i_index == i_ctrl.last_idx) begin
                    n_value = i_first;
                end else if (i_index < i_ctrl.last_idx) begin
                    n_value = i_right;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

### dv/tb_positional_list_insert_delete.sv
// Self-checking testbench for the positional list block: directed and random command traffic with scoreboard.
`timescale 1ns / 1ps
module tb_positional_list_insert_delete;
    import pld_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int ITEM_TARGET    = 370;
    localparam int CALM_ITEMS     = 50;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic [1:0]              command;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] new_value;
    } t_list_cmd;

    typedef struct {
        logic [1:0]              kind;
        logic [1:0]              status;
        logic signed [VAL_W-1:0] value;
        logic [LEN_W-1:0]        length;
        logic                    last;
    } t_list_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pld_cmd_if cmd_if ();
    pld_res_if res_if ();

    positional_list_insert_delete u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    t_list_cmd               cmd_backlog[$];
    t_list_result            awaited_results[$];
    logic signed [VAL_W-1:0] list_entries[$];
    int                      planned_len = 0;
    int                      fault_count = 0;
    int                      send_gap = 0;
    int                      sink_stall = 0;
    int                      quiet_cycles = 0;
    logic [15:0]             cycle_count = '0;
    logic                    calm_tail = 1'b0;

    always #10 i_clk = ~i_clk;

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endtask

    function automatic void apply_list_command(input logic [1:0] command,
                                               input logic [POS_W-1:0] position,
                                               input logic signed [VAL_W-1:0] value);
        logic [1:0]   status;
        int           count;
        t_list_result r;
        count = list_entries.size();
        status = STATUS_RANGE;
        if (command == CMD_PRINT) begin
            if (count == 0) begin
                r = '{KIND_EMPTY, STATUS_DONE, 32'sd0, '0, 1'b1};
                awaited_results.push_back(r);
            end else begin
                for (int i = 0; i < count; i++) begin
                    r = '{KIND_ELEMENT, STATUS_DONE, list_entries[i], LEN_W'(count),
                          i == count - 1};
                    awaited_results.push_back(r);
                end
            end
            return;
        end
        if (command == CMD_INSERT) begin
            if (position >= 1 && position <= count + 1) begin
                status = (count >= LIST_CAPACITY) ? STATUS_FULL : STATUS_DONE;
            end
            if (status == STATUS_DONE) begin
                list_entries.insert(int'(position) - 1, value);
            end
        end else if (command == CMD_DELETE) begin
            if (position >= 1 && position <= count) begin
                status = STATUS_DONE;
                list_entries.delete(int'(position) - 1);
            end
        end
        r = '{KIND_ACK, status, 32'sd0, LEN_W'(list_entries.size()), 1'b1};
        awaited_results.push_back(r);
    endfunction

    function automatic void queue_cmd(input logic [1:0] command, input int pos,
                                      input logic signed [VAL_W-1:0] value);
        t_list_cmd c;
        c.command = command;
        c.position = POS_W'(pos);
        c.new_value = value;
        cmd_backlog.push_back(c);
        if (command == CMD_INSERT && pos >= 1 && pos <= planned_len + 1
                && planned_len < LIST_CAPACITY) begin
            planned_len++;
        end else if (command == CMD_DELETE && pos >= 1 && pos <= planned_len) begin
            planned_len--;
        end
    endfunction

    function automatic void queue_random(input bit grow);
        int r;
        int insert_cut;
        r = $urandom_range(0, 99);
        insert_cut = grow ? 80 : 30;
        if (r < 10) begin
            queue_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom);
        end else if (r < 17) begin
            queue_cmd(CMD_PRINT, $urandom_range(0, 63), $urandom);
        end else if (r < insert_cut || planned_len == 0) begin
            queue_cmd(CMD_INSERT, $urandom_range(1, planned_len + 1), $urandom);
        end else begin
            queue_cmd(CMD_DELETE, $urandom_range(1, planned_len), $urandom);
        end
    endfunction

    initial begin
        cmd_if.valid = 1'b0;
        cmd_if.command = CMD_INSERT;
        cmd_if.position = '0;
        cmd_if.new_value = '0;
        res_if.ready = 1'b0;

        queue_cmd(CMD_PRINT, 0, 0);
        queue_cmd(CMD_DELETE, 1, 0);
        queue_cmd(CMD_INSERT, 0, 5);
        queue_cmd(CMD_INSERT, 2, 6);
        queue_cmd(CMD_INSERT, 1, 32'sh7fffffff);
        queue_cmd(CMD_INSERT, 1, 32'sh80000000);
        queue_cmd(CMD_INSERT, 3, -1);
        queue_cmd(CMD_INSERT, 2, 0);
        queue_cmd(CMD_INSERT, 63, $urandom);
        queue_cmd(CMD_PRINT, 63, 32'sh7fffffff);
        queue_cmd(CMD_DELETE, 0, 0);
        queue_cmd(CMD_DELETE, 5, 0);
        queue_cmd(CMD_DELETE, 4, 0);
        queue_cmd(CMD_DELETE, 1, 0);
        queue_cmd(CMD_INSERT, 2, $urandom);
        queue_cmd(CMD_DELETE, 2, 0);
        queue_cmd(CMD_UNUSED, 1, $urandom);
        queue_cmd(CMD_UNUSED, 63, -1);
        queue_cmd(CMD_PRINT, 0, 0);

        repeat (2) begin
            while (planned_len < LIST_CAPACITY) begin
                queue_random(1'b1);
            end
            queue_cmd(CMD_INSERT, LIST_CAPACITY + 1, $urandom);
            queue_cmd(CMD_INSERT, 1, $urandom);
            queue_cmd(CMD_INSERT, LIST_CAPACITY + 2, $urandom);
            queue_cmd(CMD_INSERT, 63, $urandom);
            queue_cmd(CMD_PRINT, 0, 0);
            queue_cmd(CMD_DELETE, LIST_CAPACITY + 1, 0);
            queue_cmd(CMD_DELETE, LIST_CAPACITY, 0);
            queue_cmd(CMD_INSERT, LIST_CAPACITY, $urandom);
            while (planned_len > 0) begin
                queue_random(1'b0);
            end
            queue_cmd(CMD_PRINT, 0, 0);
            repeat (30) begin
                queue_random($urandom_range(0, 1));
            end
        end
        while (cmd_backlog.size() < ITEM_TARGET) begin
            queue_random($urandom_range(0, 1));
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || cmd_if.valid) @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("positional_list_insert_delete regression: pass");
        end else begin
            $display("positional_list_insert_delete regression: fail");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1'b1;
        calm_tail <= (cmd_backlog.size() < CALM_ITEMS);
    end

    // command driver
    always @(posedge i_clk) begin
        t_list_cmd c;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                apply_list_command(cmd_if.command, cmd_if.position, cmd_if.new_value);
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    cmd_if.valid <= 1'b0;
                end else if (cmd_backlog.size() != 0 && !calm_tail && cycle_count[6]
                             && $urandom_range(0, 4) == 0) begin
                    send_gap = $urandom_range(0, 3);
                    cmd_if.valid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    c = cmd_backlog.pop_front();
                    cmd_if.valid <= 1'b1;
                    cmd_if.command <= c.command;
                    cmd_if.position <= c.position;
                    cmd_if.new_value <= c.new_value;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (awaited_results.size() == 0) begin
                    report_fault($sformatf(
                        "unexpected result: kind %0d status %0d value %0d len %0d last %0d",
                        res_if.result_kind, res_if.op_status, res_if.element_value,
                        res_if.list_length, res_if.last_result));
                end else begin
                    want = awaited_results.pop_front();
                    if (res_if.result_kind !== want.kind || res_if.op_status !== want.status
                            || res_if.element_value !== want.value
                            || res_if.list_length !== want.length
                            || res_if.last_result !== want.last) begin
                        report_fault($sformatf({"result mismatch: expected kind %0d ",
                            "status %0d value %0d len %0d last %0d, got kind %0d ",
                            "status %0d value %0d len %0d last %0d"},
                            want.kind, want.status, want.value, want.length, want.last,
                            res_if.result_kind, res_if.op_status, res_if.element_value,
                            res_if.list_length, res_if.last_result));
                    end
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                res_if.ready <= 1'b0;
            end else if (!calm_tail && cycle_count[7] && $urandom_range(0, 4) == 0) begin
                sink_stall = $urandom_range(0, 3);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // hang detection
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("positional_list_insert_delete regression: fail");
                $finish;
            end
        end
    end

endmodule

### positional_list_insert_delete.f
hw/rtl/pld_pkg.sv
hw/rtl/pld_if.sv
hw/rtl/pld_cell.sv
hw/rtl/positional_list_insert_delete.sv
dv/tb_positional_list_insert_delete.sv
